>>> src/spq_pkg.sv
`default_nettype none

package spq_pkg;

	localparam int DEPTH_DEF         = 16;
	localparam int VALUE_BITS_DEF    = 32;
	localparam int PRIORITY_BITS_DEF = 16;
	localparam int OCC_W             = 5;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef enum logic {
		RES_FREE,
		RES_HELD
	} ctrl_state_t;

	typedef struct packed {
		logic       load;
		logic       do_ins;
		logic       do_rem;
		logic       do_clr;
		logic [1:0] res_status;
	} dp_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} dp_stat_t;

endpackage

`default_nettype wire

>>> src/sorted_priority_queue_top.sv
// The result is registered and appears in the cycle after acceptance.
// Throughput: one item per cycle unless a held result waits on
// out_ready; every cell compares against the new priority in parallel
// and shifts in the same cycle. Reset (arst_n low): queue empty, no
// result pending; entry storage is not cleared.
`default_nettype none

module sorted_priority_queue_top #(
	parameter int DEPTH         = spq_pkg::DEPTH_DEF,
	parameter int VALUE_BITS    = spq_pkg::VALUE_BITS_DEF,
	parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               in_valid,
	output logic                              in_ready,
	input  wire        [1:0]                  op,
	input  wire        [VALUE_BITS-1:0]       item_value,
	input  wire signed [PRIORITY_BITS-1:0]    item_priority,
	output logic                              out_valid,
	input  wire                               out_ready,
	output logic       [1:0]                  status,
	output logic       [VALUE_BITS-1:0]       head_value,
	output logic signed [PRIORITY_BITS-1:0]   head_priority,
	output logic       [spq_pkg::OCC_W-1:0]   occupancy
);

	spq_pkg::dp_cmd_t  cmd;
	spq_pkg::dp_stat_t stat;

	spq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	spq_datapath #(
		.DEPTH         (DEPTH),
		.VALUE_BITS    (VALUE_BITS),
		.PRIORITY_BITS (PRIORITY_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.item_value    (item_value),
		.item_priority (item_priority),
		.status        (status),
		.head_value    (head_value),
		.head_priority (head_priority),
		.occupancy     (occupancy)
	);

endmodule

`default_nettype wire

>>> src/spq_ctrl.sv
`default_nettype none

module spq_ctrl (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_valid,
	output logic                   in_ready,
	input  wire  [1:0]             op,
	output logic                   out_valid,
	input  wire                    out_ready,
	input  spq_pkg::dp_stat_t      stat,
	output spq_pkg::dp_cmd_t       cmd
);

	spq_pkg::ctrl_state_t state_q, state_d;
	logic accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spq_pkg::RES_FREE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		in_ready  = (state_q == spq_pkg::RES_FREE) || out_ready;
		out_valid = (state_q == spq_pkg::RES_HELD);
		accept    = in_valid && in_ready;

		state_d = state_q;
		unique case (state_q)
			spq_pkg::RES_FREE: begin
				if (accept) state_d = spq_pkg::RES_HELD;
			end
			spq_pkg::RES_HELD: begin
				if (accept) state_d = spq_pkg::RES_HELD;
				else if (out_ready) state_d = spq_pkg::RES_FREE;
			end
			default: state_d = spq_pkg::RES_FREE;
		endcase

		cmd            = '0;
		cmd.load       = accept;
		cmd.res_status = spq_pkg::ST_DONE;
		unique case (op)
			spq_pkg::OP_INSERT: begin
				if (stat.full) cmd.res_status = spq_pkg::ST_FULL;
				else cmd.do_ins = accept;
			end
			spq_pkg::OP_REMOVE: begin
				if (stat.empty) cmd.res_status = spq_pkg::ST_EMPTY;
				else cmd.do_rem = accept;
			end
			spq_pkg::OP_CLEAR: begin
				cmd.do_clr = accept;
			end
			default: begin
				cmd.res_status = spq_pkg::ST_DONE;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> src/spq_datapath.sv
`default_nettype none

module spq_datapath #(
	parameter int DEPTH         = spq_pkg::DEPTH_DEF,
	parameter int VALUE_BITS    = spq_pkg::VALUE_BITS_DEF,
	parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  spq_pkg::dp_cmd_t                  cmd,
	output spq_pkg::dp_stat_t                 stat,
	input  wire        [VALUE_BITS-1:0]       item_value,
	input  wire signed [PRIORITY_BITS-1:0]    item_priority,
	output logic       [1:0]                  status,
	output logic       [VALUE_BITS-1:0]       head_value,
	output logic signed [PRIORITY_BITS-1:0]   head_priority,
	output logic       [spq_pkg::OCC_W-1:0]   occupancy
);

	localparam int CW = $clog2(DEPTH + 1);

	logic        [VALUE_BITS-1:0]    val_q [DEPTH];
	logic signed [PRIORITY_BITS-1:0] pri_q [DEPTH];
	logic [CW-1:0]    count_q, count_d;
	logic [DEPTH-1:0] ge;
	logic [DEPTH-1:0] take_new;

	// cell keeps its entry while its priority is at least the new one
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		assign ge[i] = (CW'(i) < count_q) && (pri_q[i] >= item_priority);

		if (i == 0) begin : g_first
			assign take_new[i] = !ge[i];
		end else begin : g_rest
			assign take_new[i] = !ge[i] && ge[i-1];
		end

		always_ff @(posedge clk) begin
			if (cmd.do_ins) begin
				if (take_new[i]) begin
					val_q[i] <= item_value;
					pri_q[i] <= item_priority;
				end else if (!ge[i]) begin
					if (i > 0) begin
						val_q[i] <= val_q[(i > 0) ? i - 1 : 0];
						pri_q[i] <= pri_q[(i > 0) ? i - 1 : 0];
					end
				end
			end else if (cmd.do_rem) begin
				if (i < DEPTH - 1) begin
					val_q[i] <= val_q[(i < DEPTH - 1) ? i + 1 : i];
					pri_q[i] <= pri_q[(i < DEPTH - 1) ? i + 1 : i];
				end
			end
		end
	end

	always_comb begin
		count_d = count_q;
		if (cmd.do_ins) count_d = count_q + CW'(1);
		else if (cmd.do_rem) count_d = count_q - CW'(1);
		else if (cmd.do_clr) count_d = '0;
	end

	assign stat.full  = (count_q == CW'(DEPTH));
	assign stat.empty = (count_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			status        <= cmd.res_status;
			head_value    <= cmd.do_rem ? val_q[0] : '0;
			head_priority <= cmd.do_rem ? pri_q[0] : '0;
			occupancy     <= spq_pkg::OCC_W'(count_d);
		end
	end

endmodule

`default_nettype wire

>>> src/spq_checker.sv
`default_nettype none

module spq_checker #(
	parameter int VALUE_BITS    = spq_pkg::VALUE_BITS_DEF,
	parameter int PRIORITY_BITS = spq_pkg::PRIORITY_BITS_DEF
) (
	input wire                             clk,
	input wire                             arst_n,
	input wire                             in_valid,
	input wire                             in_ready,
	input wire        [1:0]                op,
	input wire                             out_valid,
	input wire                             out_ready,
	input wire        [1:0]                status,
	input wire        [VALUE_BITS-1:0]     head_value,
	input wire signed [PRIORITY_BITS-1:0]  head_priority,
	input wire        [spq_pkg::OCC_W-1:0] occupancy
);

	logic accept;
	assign accept = in_valid && in_ready;

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid)
		else $error("no result after accepted item");

	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(head_value)
			&& $stable(head_priority) && $stable(occupancy))
		else $error("stalled result changed");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		accept && op == spq_pkg::OP_CLEAR |=> status == spq_pkg::ST_DONE && occupancy == '0)
		else $error("clear did not empty queue");

	a_head_zero: assert property (@(posedge clk) disable iff (!arst_n)
		accept && op != spq_pkg::OP_REMOVE |=> head_value == '0 && head_priority == '0)
		else $error("head fields set on non-remove item");

	a_empty_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == spq_pkg::ST_EMPTY |-> occupancy == '0)
		else $error("empty status with entries held");

endmodule

bind sorted_priority_queue_top spq_checker #(
	.VALUE_BITS    (VALUE_BITS),
	.PRIORITY_BITS (PRIORITY_BITS)
) u_spq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.op            (op),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.status        (status),
	.head_value    (head_value),
	.head_priority (head_priority),
	.occupancy     (occupancy)
);

`default_nettype wire

>>> tb/sv/sorted_priority_queue_top_tb.sv
`timescale 1ns / 1ps

module sorted_priority_queue_top_tb;

	localparam int QDEPTH = spq_pkg::DEPTH_DEF;
	localparam int VW     = spq_pkg::VALUE_BITS_DEF;
	localparam int PW     = spq_pkg::PRIORITY_BITS_DEF;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct {
		logic [1:0]                status;
		logic [VW-1:0]             value;
		logic signed [PW-1:0]      prio;
		logic [spq_pkg::OCC_W-1:0] occ;
	} pq_result_t;

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_ready;
	logic [1:0]                op;
	logic [VW-1:0]             item_value;
	logic signed [PW-1:0]      item_priority;
	logic                      out_valid;
	logic                      out_ready;
	logic [1:0]                status;
	logic [VW-1:0]             head_value;
	logic signed [PW-1:0]      head_priority;
	logic [spq_pkg::OCC_W-1:0] occupancy;

	logic [VW-1:0]        model_values [QDEPTH];
	logic signed [PW-1:0] model_prios [QDEPTH];
	int                   model_count;
	pq_result_t           expected_results [$];
	int                   mismatch_count;
	int                   cycle_count;
	bit                   tx_idle_on;
	bit                   rx_idle_on;

	sorted_priority_queue_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.op            (op),
		.item_value    (item_value),
		.item_priority (item_priority),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.head_value    (head_value),
		.head_priority (head_priority),
		.occupancy     (occupancy)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("MISMATCH %s: got %0h, expected %0h", what, got, want);
		mismatch_count++;
	endtask

	// sorted insert behind equal priorities, pop from head
	function automatic pq_result_t predict_queue_op(input logic [1:0] code,
			input logic [VW-1:0] v, input logic signed [PW-1:0] p);
		pq_result_t r;
		int pos;
		r.status = spq_pkg::ST_DONE;
		r.value = '0;
		r.prio = '0;
		case (code)
			spq_pkg::OP_INSERT: begin
				if (model_count >= QDEPTH) begin
					r.status = spq_pkg::ST_FULL;
				end else begin
					pos = 0;
					while (pos < model_count && model_prios[pos] >= p)
						pos++;
					for (int i = model_count; i > pos; i--) begin
						model_values[i] = model_values[i-1];
						model_prios[i] = model_prios[i-1];
					end
					model_values[pos] = v;
					model_prios[pos] = p;
					model_count++;
				end
			end
			spq_pkg::OP_REMOVE: begin
				if (model_count == 0) begin
					r.status = spq_pkg::ST_EMPTY;
				end else begin
					r.value = model_values[0];
					r.prio = model_prios[0];
					for (int i = 1; i < model_count; i++) begin
						model_values[i-1] = model_values[i];
						model_prios[i-1] = model_prios[i];
					end
					model_count--;
				end
			end
			spq_pkg::OP_CLEAR: begin
				model_count = 0;
			end
			default: begin
			end
		endcase
		r.occ = model_count[spq_pkg::OCC_W-1:0];
		return r;
	endfunction

	task automatic send_item(input logic [1:0] code, input logic [VW-1:0] v,
			input logic signed [PW-1:0] p);
		if (tx_idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		in_valid <= 1'b1;
		op <= code;
		item_value <= v;
		item_priority <= p;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		expected_results.push_back(predict_queue_op(code, v, p));
		@(negedge clk);
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (rx_idle_on && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 10) - 1) @(negedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		pq_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result", {62'd0, status}, 64'd0);
			end else begin
				want = expected_results.pop_front();
				if (status !== want.status)
					report_mismatch("status", 64'(status), 64'(want.status));
				if (head_value !== want.value)
					report_mismatch("head_value", 64'(head_value), 64'(want.value));
				if (head_priority !== want.prio)
					report_mismatch("head_priority", 64'(head_priority),
						64'(want.prio));
				if (occupancy !== want.occ)
					report_mismatch("occupancy", 64'(occupancy), 64'(want.occ));
			end
		end
	end

	function automatic logic signed [PW-1:0] rand_prio();
		case ($urandom_range(0, 3))
			0: return $signed(PW'($urandom_range(0, 6))) - 16'sd3;
			1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
			default: return PW'($urandom);
		endcase
	endfunction

	task automatic test_empty_ops();
		send_item(spq_pkg::OP_REMOVE, 32'h1234_5678, 16'sd5);
		send_item(OP_UNUSED, 32'hffff_ffff, 16'sh7fff);
		send_item(spq_pkg::OP_CLEAR, 32'h0, 16'sh8000);
	endtask

	// extremes of value and priority, plus a run of ties
	task automatic test_fill_to_full();
		send_item(spq_pkg::OP_INSERT, 32'h0000_0000, 16'sh8000);
		send_item(spq_pkg::OP_INSERT, 32'hffff_ffff, 16'sh7fff);
		send_item(spq_pkg::OP_INSERT, 32'h0000_0001, 16'sd0);
		send_item(spq_pkg::OP_INSERT, 32'h8000_0000, -16'sd1);
		send_item(spq_pkg::OP_INSERT, 32'h5555_5555, 16'sd1);
		for (int i = 0; i < 4; i++)
			send_item(spq_pkg::OP_INSERT, 32'hcafe_0000 + i, 16'sd7);
		send_item(spq_pkg::OP_INSERT, 32'haaaa_aaaa, 16'sh7fff);
		send_item(spq_pkg::OP_INSERT, 32'h7fff_ffff, 16'sh8000);
		for (int i = 0; i < 5; i++)
			send_item(spq_pkg::OP_INSERT, $urandom, rand_prio());
	endtask

	task automatic test_full_insert();
		send_item(spq_pkg::OP_INSERT, 32'hdead_beef, 16'sh7fff);
		send_item(OP_UNUSED, 32'h0, 16'sd0);
	endtask

	task automatic test_remove_and_clear();
		send_item(spq_pkg::OP_REMOVE, 32'h0, 16'sd0);
		send_item(spq_pkg::OP_REMOVE, 32'h0, 16'sd0);
		send_item(spq_pkg::OP_CLEAR, 32'h0, 16'sd0);
		send_item(spq_pkg::OP_REMOVE, 32'h0, 16'sd0);
	endtask

	task automatic random_run(input int count, input int insert_pct);
		int r;
		logic [1:0] code;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(0, 99);
			if (r < 2)
				code = spq_pkg::OP_CLEAR;
			else if (r < 4)
				code = OP_UNUSED;
			else if (r < 4 + insert_pct)
				code = spq_pkg::OP_INSERT;
			else
				code = spq_pkg::OP_REMOVE;
			send_item(code, $urandom, rand_prio());
		end
	endtask

	task automatic test_random_mix();
		for (int ph = 0; ph < 6; ph++) begin
			random_run(40, 76);
			random_run(30, 20);
			if (ph == 2)
				wait_drain();
		end
	endtask

	task automatic test_random_no_idle();
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		random_run(70, 60);
		random_run(60, 30);
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = spq_pkg::OP_INSERT;
		item_value = '0;
		item_priority = '0;
		model_count = 0;
		mismatch_count = 0;
		cycle_count = 0;
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_empty_ops();
		test_fill_to_full();
		test_full_insert();
		test_remove_and_clear();
		wait_drain();
		test_random_mix();
		test_random_no_idle();

		wait_drain();
		repeat (8) @(negedge clk);
		if (expected_results.size() != 0)
			report_mismatch("missing results", 64'd0, 64'(expected_results.size()));
		if (mismatch_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

>>> filelist.f
src/spq_pkg.sv
src/spq_ctrl.sv
src/spq_datapath.sv
src/sorted_priority_queue_top.sv
src/spq_checker.sv
tb/sv/sorted_priority_queue_top_tb.sv
